@@ rtl/bsp_pkg.sv @@
// bsp_pkg: shared widths, latencies, register codes and fixed-point helpers
// for the box support point block. No dependencies.
`default_nettype none

package bsp_pkg;

  localparam int W         = 32;  // port word width
  localparam int PROD_W    = 64;  // 32x32 product
  localparam int TERM_W    = 34;  // product rounded by 2^30
  localparam int PT_W      = 36;  // corner point coordinate, never wraps
  localparam int DOT_W     = 70;  // exact dot product of direction and point
  localparam int EXT_W     = 40;  // headroom for sums ahead of saturation
  localparam int CORNERS   = 8;
  localparam int ROOT_STEPS = 32; // one result bit per step
  localparam int NUM_W     = 63;  // |bias * e| plus half the length
  localparam int QUO_W     = 34;  // quotient bits that can be set
  localparam int REM_W     = 33;
  localparam int OFS_W     = 35;
  localparam int SEL_LAT   = 11;  // rotation, corner and selection stages
  localparam int OFS_LAT   = 73;  // normalization, root and divide stages
  localparam int PT_DLY    = OFS_LAT - SEL_LAT;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [W-1:0] min_x;
    logic signed [W-1:0] min_y;
    logic signed [W-1:0] min_z;
    logic signed [W-1:0] max_x;
    logic signed [W-1:0] max_y;
    logic signed [W-1:0] max_z;
  } box_t;

  // divide by 2^30, rounding half toward +inf
  function automatic logic signed [TERM_W-1:0] round30(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + 64'sd536870912;
    return t[PROD_W-1:30];
  endfunction

  function automatic logic signed [W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [W-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/box_support_point.sv @@
// box_support_point: support mapping of an oriented box for collision tests.
// Instantiates bsp_select and bsp_offset; uses bsp_pkg.
//
// usage
//   configuration: write the six corner registers (index 0..5: min x/y/z,
//   max x/y/z) through cfg_valid/cfg_index/cfg_data while no query is in
//   flight; cfg_ready is always high, unknown indexes are dropped
//   input channel: in_valid/in_stall, one query per transfer (direction,
//   translation, quaternion, bias); one support point per query
//   output channel: out_valid/out_stall carrying support_x/y/z
//   throughput: one query per cycle while in_stall is low; the pipeline is 73 stages of which
//   32 are the square root and 34 the restoring divide of the normalizer
//   stalls: a two-entry output queue parts the pipeline from the receiver;
//   the pipeline advances as a whole while the queue has room, so a query
//   is still taken while one finished result waits; in_stall rises only
//   when both entries are full and comes straight from a register
//   reset: valid bits and the queue clear, box registers read zero
`default_nettype none

module box_support_point (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bsp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bsp_pkg::W-1:0]                 cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [bsp_pkg::W-1:0]          dir_x,
  input  wire logic signed [bsp_pkg::W-1:0]          dir_y,
  input  wire logic signed [bsp_pkg::W-1:0]          dir_z,
  input  wire logic signed [bsp_pkg::W-1:0]          pos_x,
  input  wire logic signed [bsp_pkg::W-1:0]          pos_y,
  input  wire logic signed [bsp_pkg::W-1:0]          pos_z,
  input  wire logic signed [bsp_pkg::W-1:0]          rot_x,
  input  wire logic signed [bsp_pkg::W-1:0]          rot_y,
  input  wire logic signed [bsp_pkg::W-1:0]          rot_z,
  input  wire logic signed [bsp_pkg::W-1:0]          rot_w,
  input  wire logic signed [bsp_pkg::W-1:0]          bias,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [bsp_pkg::W-1:0]               support_x,
  output logic signed [bsp_pkg::W-1:0]               support_y,
  output logic signed [bsp_pkg::W-1:0]               support_z
);

  localparam int LAT = bsp_pkg::OFS_LAT;

  bsp_pkg::box_t box;

  logic                               adv;       // whole pipeline moves
  logic [LAT:1]                       vld;       // valid bit per stage
  logic signed [bsp_pkg::W-1:0]       dir [3];
  logic signed [bsp_pkg::W-1:0]       pos [3];
  logic signed [bsp_pkg::PT_W-1:0]    best [3];
  logic signed [bsp_pkg::OFS_W-1:0]   ofs [3];
  logic signed [bsp_pkg::PT_W-1:0]    pt_dly [bsp_pkg::PT_DLY][3];
  logic signed [bsp_pkg::W-1:0]       res [3];

  // output queue
  logic [1:0]                         cnt;
  logic [1:0]                         cnt_next;
  logic signed [bsp_pkg::W-1:0]       head [3];
  logic signed [bsp_pkg::W-1:0]       tail [3];
  logic                               push;
  logic                               pop;

  assign cfg_ready = 1'b1;

  // box registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (bsp_pkg::cfg_reg_t'(cfg_index))
        bsp_pkg::CFG_BOX_MIN_X: box.min_x <= cfg_data;
        bsp_pkg::CFG_BOX_MIN_Y: box.min_y <= cfg_data;
        bsp_pkg::CFG_BOX_MIN_Z: box.min_z <= cfg_data;
        bsp_pkg::CFG_BOX_MAX_X: box.max_x <= cfg_data;
        bsp_pkg::CFG_BOX_MAX_Y: box.max_y <= cfg_data;
        bsp_pkg::CFG_BOX_MAX_Z: box.max_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // the pipeline may move unless the queue is full
  assign adv      = (cnt != 2'd2);
  assign in_stall = !adv;

  assign dir = '{dir_x, dir_y, dir_z};
  assign pos = '{pos_x, pos_y, pos_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // rotated corners and the winning one
  bsp_select u_select (
    .clk   (clk),
    .adv   (adv),
    .box   (box),
    .dir   (dir),
    .pos   (pos),
    .rot_x (rot_x),
    .rot_y (rot_y),
    .rot_z (rot_z),
    .rot_w (rot_w),
    .best  (best)
  );

  // bias along the normalized direction
  bsp_offset u_offset (
    .clk  (clk),
    .adv  (adv),
    .dir  (dir),
    .bias (bias),
    .ofs  (ofs)
  );

  // hold the chosen point until its offset is ready
  always_ff @(posedge clk) begin
    if (adv) begin
      pt_dly[0] <= best;
      for (int s = 1; s < bsp_pkg::PT_DLY; s++) pt_dly[s] <= pt_dly[s-1];
    end
  end

  // final add and saturation feed the queue directly
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      res[j] = bsp_pkg::sat32(
        {{(bsp_pkg::EXT_W-bsp_pkg::PT_W){pt_dly[bsp_pkg::PT_DLY-1][j][bsp_pkg::PT_W-1]}},
         pt_dly[bsp_pkg::PT_DLY-1][j]}
        + {{(bsp_pkg::EXT_W-bsp_pkg::OFS_W){ofs[j][bsp_pkg::OFS_W-1]}}, ofs[j]});
    end
  end

  assign push = adv && vld[LAT];
  assign pop  = (cnt != 2'd0) && !out_stall;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (!push && pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // head is the presented result, tail the second entry
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        head <= res;
      end else begin
        head <= tail;
        tail <= res;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        head <= res;
      end else begin
        tail <= res;
      end
    end else if (pop) begin
      head <= tail;
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign support_x = head[0];
  assign support_y = head[1];
  assign support_z = head[2];

  // queue never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("output queue count out of range");

  // a held pipeline keeps every valid bit
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld)) else $error("valid bits moved while held");

  // nothing in flight and nothing queued gives no result next cycle
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && vld == '0) |=> !out_valid)
    else $error("result with no query in flight");

endmodule

`default_nettype wire

@@ rtl/bsp_select.sv @@
// bsp_select: rotation matrix, eight transformed corners, exact dot products
// and a registered max tree. Uses bsp_pkg.
`default_nettype none

module bsp_select (
  input  wire logic                            clk,
  input  wire logic                            adv,
  input  wire bsp_pkg::box_t                   box,
  input  wire logic signed [bsp_pkg::W-1:0]    dir [3],
  input  wire logic signed [bsp_pkg::W-1:0]    pos [3],
  input  wire logic signed [bsp_pkg::W-1:0]    rot_x,
  input  wire logic signed [bsp_pkg::W-1:0]    rot_y,
  input  wire logic signed [bsp_pkg::W-1:0]    rot_z,
  input  wire logic signed [bsp_pkg::W-1:0]    rot_w,
  output logic signed [bsp_pkg::PT_W-1:0]      best [3]
);

  localparam int EW = bsp_pkg::EXT_W;
  localparam int TW = bsp_pkg::TERM_W;

  // quaternion products: xx yy zz ww xy xz yz wx wy wz
  logic signed [bsp_pkg::PROD_W-1:0] qp [10];
  logic signed [TW-1:0]              qr [10];
  logic signed [EW-1:0]              ms [9];
  logic signed [bsp_pkg::W-1:0]      m  [9];
  logic signed [bsp_pkg::W-1:0]      cor [bsp_pkg::CORNERS][3];
  logic signed [bsp_pkg::PROD_W-1:0] cp [bsp_pkg::CORNERS][9];
  logic signed [TW-1:0]              ct [bsp_pkg::CORNERS][9];
  logic signed [bsp_pkg::PT_W-1:0]   p6 [bsp_pkg::CORNERS][3];
  logic signed [bsp_pkg::PT_W-1:0]   p7 [bsp_pkg::CORNERS][3];
  logic signed [bsp_pkg::PT_W-1:0]   p8 [bsp_pkg::CORNERS][3];
  logic signed [67:0]                dp [bsp_pkg::CORNERS][3];
  logic signed [bsp_pkg::DOT_W-1:0]  dot [bsp_pkg::CORNERS];
  logic signed [bsp_pkg::DOT_W-1:0]  l1_dot [4];
  logic signed [bsp_pkg::PT_W-1:0]   l1_p [4][3];
  logic signed [bsp_pkg::DOT_W-1:0]  l2_dot [2];
  logic signed [bsp_pkg::PT_W-1:0]   l2_p [2][3];
  logic signed [bsp_pkg::W-1:0]      dsh [6][3];
  logic signed [bsp_pkg::W-1:0]      psh [5][3];

  function automatic logic signed [EW-1:0] ext(input logic signed [TW-1:0] v);
    return {{(EW-TW){v[TW-1]}}, v};
  endfunction

  // matrix entries ahead of saturation, row-major
  always_comb begin
    ms[0] = ext(qr[3]) + ext(qr[0]) - ext(qr[1]) - ext(qr[2]);
    ms[1] = (ext(qr[4]) - ext(qr[9])) <<< 1;
    ms[2] = (ext(qr[5]) + ext(qr[8])) <<< 1;
    ms[3] = (ext(qr[4]) + ext(qr[9])) <<< 1;
    ms[4] = ext(qr[3]) - ext(qr[0]) + ext(qr[1]) - ext(qr[2]);
    ms[5] = (ext(qr[6]) - ext(qr[7])) <<< 1;
    ms[6] = (ext(qr[5]) - ext(qr[8])) <<< 1;
    ms[7] = (ext(qr[6]) + ext(qr[7])) <<< 1;
    ms[8] = ext(qr[3]) - ext(qr[0]) - ext(qr[1]) + ext(qr[2]);
  end

  // corner i: bit0 max x, bit1 max y, bit2 max z
  always_comb begin
    for (int i = 0; i < bsp_pkg::CORNERS; i++) begin
      cor[i][0] = ((i & 1) != 0) ? box.max_x : box.min_x;
      cor[i][1] = ((i & 2) != 0) ? box.max_y : box.min_y;
      cor[i][2] = ((i & 4) != 0) ? box.max_z : box.min_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      qp[0] <= rot_x * rot_x;
      qp[1] <= rot_y * rot_y;
      qp[2] <= rot_z * rot_z;
      qp[3] <= rot_w * rot_w;
      qp[4] <= rot_x * rot_y;
      qp[5] <= rot_x * rot_z;
      qp[6] <= rot_y * rot_z;
      qp[7] <= rot_w * rot_x;
      qp[8] <= rot_w * rot_y;
      qp[9] <= rot_w * rot_z;
      dsh[0] <= dir;
      psh[0] <= pos;
      for (int s = 1; s < 6; s++) dsh[s] <= dsh[s-1];
      for (int s = 1; s < 5; s++) psh[s] <= psh[s-1];
      // stage 2
      for (int k = 0; k < 10; k++) qr[k] <= bsp_pkg::round30(qp[k]);
      // stage 3
      for (int k = 0; k < 9; k++) m[k] <= bsp_pkg::sat32(ms[k]);
      for (int i = 0; i < bsp_pkg::CORNERS; i++) begin
        // stage 4
        for (int r = 0; r < 3; r++) begin
          for (int j = 0; j < 3; j++) cp[i][r*3+j] <= m[r*3+j] * cor[i][j];
        end
        // stage 5
        for (int k = 0; k < 9; k++) ct[i][k] <= bsp_pkg::round30(cp[i][k]);
        // stage 6
        for (int r = 0; r < 3; r++) begin
          p6[i][r] <= {{(bsp_pkg::PT_W-bsp_pkg::W){psh[4][r][bsp_pkg::W-1]}}, psh[4][r]}
                    + {{(bsp_pkg::PT_W-TW){ct[i][r*3][TW-1]}},   ct[i][r*3]}
                    + {{(bsp_pkg::PT_W-TW){ct[i][r*3+1][TW-1]}}, ct[i][r*3+1]}
                    + {{(bsp_pkg::PT_W-TW){ct[i][r*3+2][TW-1]}}, ct[i][r*3+2]};
        end
        // stage 7
        for (int r = 0; r < 3; r++) dp[i][r] <= dsh[5][r] * p6[i][r];
        p7[i] <= p6[i];
        // stage 8
        dot[i] <= {{2{dp[i][0][67]}}, dp[i][0]} + {{2{dp[i][1][67]}}, dp[i][1]}
                + {{2{dp[i][2][67]}}, dp[i][2]};
        p8[i] <= p7[i];
      end
      // stages 9 to 11: the lower index keeps ties
      for (int k = 0; k < 4; k++) begin
        if (dot[2*k+1] > dot[2*k]) begin
          l1_dot[k] <= dot[2*k+1];
          l1_p[k]   <= p8[2*k+1];
        end else begin
          l1_dot[k] <= dot[2*k];
          l1_p[k]   <= p8[2*k];
        end
      end
      for (int k = 0; k < 2; k++) begin
        if (l1_dot[2*k+1] > l1_dot[2*k]) begin
          l2_dot[k] <= l1_dot[2*k+1];
          l2_p[k]   <= l1_p[2*k+1];
        end else begin
          l2_dot[k] <= l1_dot[2*k];
          l2_p[k]   <= l1_p[2*k];
        end
      end
      if (l2_dot[1] > l2_dot[0]) begin
        best <= l2_p[1];
      end else begin
        best <= l2_p[0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsp_offset.sv @@
// bsp_offset: bias times the normalized direction. Scales the direction,
// takes a pipelined integer square root and three pipelined dividers. Uses bsp_pkg.
`default_nettype none

module bsp_offset (
  input  wire logic                              clk,
  input  wire logic                              adv,
  input  wire logic signed [bsp_pkg::W-1:0]      dir [3],
  input  wire logic signed [bsp_pkg::W-1:0]      bias,
  output logic signed [bsp_pkg::OFS_W-1:0]       ofs [3]
);

  localparam int RS = bsp_pkg::ROOT_STEPS;
  localparam int QW = bsp_pkg::QUO_W;
  localparam int NW = bsp_pkg::NUM_W;
  localparam int RW = bsp_pkg::REM_W;

  logic        [bsp_pkg::W-1:0]  ad [3];
  logic signed [bsp_pkg::W-1:0]  d1 [3];
  logic signed [bsp_pkg::W-1:0]  d2 [3];
  logic signed [bsp_pkg::W-1:0]  b1, b2, b3;
  logic        [bsp_pkg::W-1:0]  orv;
  logic        [4:0]             msb;
  logic        [4:0]             k_next;
  logic        [4:0]             k;
  logic signed [32:0]            e [3];
  logic signed [65:0]            esq [3];
  logic signed [64:0]            be [3];

  // square root pipeline, index 0 is the sum of squares
  logic [63:0] sq_n   [RS+1];
  logic [64:0] sq_res [RS+1];
  logic [NW-1:0] sq_nm [RS+1][3];
  logic [2:0]    sq_neg [RS+1];

  // divider pipeline, index 0 holds the rounded numerator
  logic [NW-1:0]         dv_num [QW+1][3];
  logic [RW-1:0]         dv_rem [QW+1][3];
  logic [QW-1:0]         dv_quo [QW+1][3];
  logic [bsp_pkg::W-1:0] dv_den [QW+1];
  logic [2:0]            dv_neg [QW+1];
  logic                  dv_zero [QW+1];

  // highest set bit of the magnitudes gives the scale
  always_comb begin
    orv = ad[0] | ad[1] | ad[2];
    msb = '0;
    for (int b = 0; b < bsp_pkg::W; b++) begin
      if (orv[b]) msb = 5'(b);
    end
    k_next = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        ad[j] <= dir[j][bsp_pkg::W-1] ? 32'(-dir[j]) : dir[j];
        d1[j] <= dir[j];
        d2[j] <= d1[j];
        e[j]  <= {d2[j][bsp_pkg::W-1], d2[j]} <<< k;
        esq[j] <= e[j] * e[j];
        be[j]  <= b3 * e[j];
        sq_nm[0][j]  <= be[j][64] ? NW'(-be[j]) : be[j][NW-1:0];
        sq_neg[0][j] <= be[j][64];
      end
      b1 <= bias;
      b2 <= b1;
      b3 <= b2;
      k  <= k_next;
      sq_n[0]   <= esq[0][63:0] + esq[1][63:0] + esq[2][63:0];
      sq_res[0] <= '0;
    end
  end

  for (genvar s = 0; s < RS; s++) begin : g_root
    localparam logic [64:0] BIT = 65'd1 << (2 * (RS - 1 - s));
    logic [64:0] trial;
    logic        ge;
    assign trial = sq_res[s] + BIT;
    assign ge    = {1'b0, sq_n[s]} >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ge) begin
          sq_n[s+1]   <= sq_n[s] - trial[63:0];
          sq_res[s+1] <= (sq_res[s] >> 1) + BIT;
        end else begin
          sq_n[s+1]   <= sq_n[s];
          sq_res[s+1] <= sq_res[s] >> 1;
        end
        sq_nm[s+1]  <= sq_nm[s];
        sq_neg[s+1] <= sq_neg[s];
      end
    end
  end

  // round to nearest: add half the length ahead of the divide
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        dv_num[0][j] <= sq_nm[RS][j] + NW'(sq_res[RS][bsp_pkg::W-1:1]);
        dv_rem[0][j] <= RW'((sq_nm[RS][j] + NW'(sq_res[RS][bsp_pkg::W-1:1])) >> QW);
        dv_quo[0][j] <= '0;
      end
      dv_den[0]  <= sq_res[RS][bsp_pkg::W-1:0];
      dv_neg[0]  <= sq_neg[RS];
      dv_zero[0] <= (sq_res[RS][bsp_pkg::W-1:0] == '0);
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_div
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [RW-1:0] r2;
      logic          ge;
      assign r2 = {dv_rem[t][j][RW-2:0], dv_num[t][j][QW-1-t]};
      assign ge = r2 >= {1'b0, dv_den[t]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[t+1][j] <= ge ? r2 - {1'b0, dv_den[t]} : r2;
          dv_quo[t+1][j] <= {dv_quo[t][j][QW-2:0], ge};
          dv_num[t+1][j] <= dv_num[t][j];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den[t+1]  <= dv_den[t];
        dv_neg[t+1]  <= dv_neg[t];
        dv_zero[t+1] <= dv_zero[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        if (dv_zero[QW]) begin
          ofs[j] <= '0;
        end else if (dv_neg[QW][j]) begin
          ofs[j] <= -$signed({1'b0, dv_quo[QW][j]});
        end else begin
          ofs[j] <= $signed({1'b0, dv_quo[QW][j]});
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// testbench: self-checking bench for box_support_point, the oriented box support mapping
// drives queries, corner register writes and receiver backpressure; predicts each support point
// depends on bsp_pkg and box_support_point in rtl/
`default_nettype none

module testbench;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  DRAIN_CYCLES = 120;     // well past the time the pipeline takes to empty
  localparam int  PHASE_ITEMS  = 280;
  localparam logic [bsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;  // unused indexes, dropped
  localparam logic [bsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic signed [31:0] Q_ONE  = 32'sd1073741824;  // 1.0 in Q2.30
  localparam logic signed [31:0] Q_HALF = 32'sd759250125;   // 1/sqrt(2) in Q2.30
  localparam logic signed [31:0] S_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN  = 32'sh80000000;

  typedef struct {
    logic signed [31:0] dx, dy, dz, px, py, pz, qx, qy, qz, qw, b;
  } query_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } point_t;

  // scoreboard: keeps its own copy of the box corners and the queue of support points
  // still owed by the block
  class support_tracker;
    longint box_lo[3];
    longint box_hi[3];
    point_t owed_points[$];

    function new();
      foreach (box_lo[i]) begin
        box_lo[i] = 0;
        box_hi[i] = 0;
      end
    endfunction

    function void set_corner(logic [bsp_pkg::CFG_IDX_W-1:0] idx, logic signed [31:0] val);
      case (idx)
        bsp_pkg::CFG_BOX_MIN_X: box_lo[0] = val;
        bsp_pkg::CFG_BOX_MIN_Y: box_lo[1] = val;
        bsp_pkg::CFG_BOX_MIN_Z: box_lo[2] = val;
        bsp_pkg::CFG_BOX_MAX_X: box_hi[0] = val;
        bsp_pkg::CFG_BOX_MAX_Y: box_hi[1] = val;
        bsp_pkg::CFG_BOX_MAX_Z: box_hi[2] = val;
        default: ;
      endcase
    endfunction

    // divide by 2^30 rounding half up
    function longint shr30_round(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint clamp32(longint v);
      longint r;
      r = v;
      if (v > 64'sd2147483647) r = 64'sd2147483647;
      if (v < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, one_bit;
      root = 0;
      one_bit = 64'd1 << 62;
      while (one_bit > n) one_bit = one_bit >> 2;
      while (one_bit != 0) begin
        if (n >= root + one_bit) begin
          n = n - (root + one_bit);
          root = (root >> 1) + one_bit;
        end else begin
          root = root >> 1;
        end
        one_bit = one_bit >> 2;
      end
      return root;
    endfunction

    function point_t predict_support(query_t q);
      longint d[3], t[3], m[3][3], c[3], p[3], best[3], e[3];
      longint x, y, z, w, xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, mx, num;
      longint unsigned sq, len, mag, quo;
      logic signed [127:0] acc, best_dot, pw, dw;
      int k;
      point_t r;
      d[0] = q.dx; d[1] = q.dy; d[2] = q.dz;
      t[0] = q.px; t[1] = q.py; t[2] = q.pz;
      x = q.qx; y = q.qy; z = q.qz; w = q.qw;
      xx = shr30_round(x * x); yy = shr30_round(y * y);
      zz = shr30_round(z * z); ww = shr30_round(w * w);
      xy = shr30_round(x * y); xz = shr30_round(x * z);
      yz = shr30_round(y * z); wx = shr30_round(w * x);
      wy = shr30_round(w * y); wz = shr30_round(w * z);
      m[0][0] = clamp32(ww + xx - yy - zz);
      m[1][1] = clamp32(ww - xx + yy - zz);
      m[2][2] = clamp32(ww - xx - yy + zz);
      m[0][1] = clamp32(2 * (xy - wz));
      m[0][2] = clamp32(2 * (xz + wy));
      m[1][0] = clamp32(2 * (xy + wz));
      m[1][2] = clamp32(2 * (yz - wx));
      m[2][0] = clamp32(2 * (xz - wy));
      m[2][1] = clamp32(2 * (yz + wx));
      best_dot = 0;
      foreach (best[i]) best[i] = 0;
      // corner index bit0/1/2 picks the max x/y/z, lowest index wins ties
      for (int i = 0; i < bsp_pkg::CORNERS; i++) begin
        c[0] = i[0] ? box_hi[0] : box_lo[0];
        c[1] = i[1] ? box_hi[1] : box_lo[1];
        c[2] = i[2] ? box_hi[2] : box_lo[2];
        acc = 0;
        for (int rr = 0; rr < 3; rr++) begin
          p[rr] = t[rr];
          for (int j = 0; j < 3; j++) p[rr] += shr30_round(m[rr][j] * c[j]);
          pw = p[rr];
          dw = d[rr];
          acc += pw * dw;
        end
        if (i == 0 || acc > best_dot) begin
          best_dot = acc;
          best = p;
        end
      end
      mx = 0;
      foreach (d[j]) begin
        mag = (d[j] < 0) ? -d[j] : d[j];
        if (mag > mx) mx = mag;
      end
      // zero direction adds no offset
      if (mx != 0) begin
        k = 0;
        while ((mx << k) < (64'sd1 << 30)) k++;
        sq = 0;
        foreach (e[j]) begin
          e[j] = d[j] <<< k;
          sq += e[j] * e[j];
        end
        len = int_sqrt(sq);
        foreach (e[j]) begin
          num = longint'(q.b) * e[j];
          mag = (num < 0) ? -num : num;
          quo = (mag + len / 2) / len;
          best[j] += (num < 0) ? -longint'(quo) : longint'(quo);
        end
      end
      r.x = 32'(clamp32(best[0]));
      r.y = 32'(clamp32(best[1]));
      r.z = 32'(clamp32(best[2]));
      return r;
    endfunction

    function void note_query(query_t q);
      owed_points.insert(owed_points.size(), predict_support(q));
    endfunction

    // empty string when the result matches the oldest owed point
    function string check_point(point_t got);
      point_t want;
      if (owed_points.size() == 0) return $sformatf("unexpected support point %0d %0d %0d",
                                                    got.x, got.y, got.z);
      want = owed_points.pop_front();
      if (got.x != want.x || got.y != want.y || got.z != want.z)
        return $sformatf("support point got %0d %0d %0d want %0d %0d %0d",
                         got.x, got.y, got.z, want.x, want.y, want.z);
      return "";
    endfunction

    function int outstanding();
      return owed_points.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bsp_pkg::W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [bsp_pkg::W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [bsp_pkg::W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [bsp_pkg::W-1:0] rot_x = '0, rot_y = '0, rot_z = '0, rot_w = '0;
  logic signed [bsp_pkg::W-1:0] bias = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [bsp_pkg::W-1:0] support_x, support_y, support_z;

  support_tracker sb = new();
  int errors = 0;
  int cycles = 0;
  bit no_gaps = 0;          // burst mode for the sender
  bit hold_req = 0;         // toggled by the main flow to ask for a long hold-off

  box_support_point u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .rot_w(rot_w),
    .bias(bias),
    .out_valid(out_valid), .out_stall(out_stall),
    .support_x(support_x), .support_y(support_y), .support_z(support_z)
  );

  always #5 clk = ~clk;

  task automatic report(string msg);
    if (errors < 20) $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // monitors: sample transfers on both channels at the edge
  always @(posedge clk) begin : watch
    query_t q;
    point_t got;
    string msg;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        q.dx = dir_x; q.dy = dir_y; q.dz = dir_z;
        q.px = pos_x; q.py = pos_y; q.pz = pos_z;
        q.qx = rot_x; q.qy = rot_y; q.qz = rot_z; q.qw = rot_w;
        q.b = bias;
        sb.note_query(q);
      end
      if (out_valid && !out_stall) begin
        got.x = support_x; got.y = support_y; got.z = support_z;
        msg = sb.check_point(got);
        if (msg != "") report(msg);
      end
    end
  end

  // receiver: random stalls, mostly short, a few long, quiet stretches,
  // and one long hold-off on request
  always @(posedge clk) begin : receiver
    int stall_left, quiet_left, hold_left, pick;
    bit seen_req;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0; quiet_left = 0; hold_left = 0; seen_req = 0;
    end else begin
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 199);
        if (pick < 130) begin
          out_stall <= 1'b0;
        end else if (pick < 185) begin
          stall_left = $urandom_range(0, 3);
          out_stall <= 1'b1;
        end else if (pick < 192) begin
          stall_left = $urandom_range(10, 50);
          out_stall <= 1'b1;
        end else begin
          quiet_left = $urandom_range(50, 200);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one query transfer; valid stays high across back-to-back items
  task automatic send_query(query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_x <= q.dx; dir_y <= q.dy; dir_z <= q.dz;
    pos_x <= q.px; pos_y <= q.py; pos_z <= q.pz;
    rot_x <= q.qx; rot_y <= q.qy; rot_z <= q.qz; rot_w <= q.qw;
    bias  <= q.b;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic end_queries();
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [bsp_pkg::CFG_IDX_W-1:0] idx, logic signed [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_corner(idx, val);
  endtask

  // writes all six corners plus a spare index that the block must drop
  task automatic load_box(logic signed [31:0] lx, ly, lz, hx, hy, hz);
    write_reg(bsp_pkg::CFG_BOX_MIN_X, lx);
    write_reg(bsp_pkg::CFG_BOX_MIN_Y, ly);
    write_reg(bsp_pkg::CFG_BOX_MIN_Z, lz);
    write_reg(bsp_pkg::CFG_BOX_MAX_X, hx);
    write_reg(bsp_pkg::CFG_BOX_MAX_Y, hy);
    write_reg(bsp_pkg::CFG_BOX_MAX_Z, hz);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every owed result, then let the pipeline empty out
  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_span(int bits);
    return $signed($urandom_range(0, (1 << bits) - 1)) - (32'sd1 <<< (bits - 1));
  endfunction

  function automatic void rand_dir(ref query_t q);
    int r;
    r = $urandom_range(0, 99);
    q.dx = $urandom; q.dy = $urandom; q.dz = $urandom;
    if (r < 30) begin
    end else if (r < 55) begin
      q.dx = rnd_span(21); q.dy = rnd_span(21); q.dz = rnd_span(21);
    end else if (r < 70) begin
      // single axis, so corners can tie in groups of four
      q.dx = 0; q.dy = 0; q.dz = 0;
      case ($urandom_range(0, 2))
        0: q.dx = rnd_span(20);
        1: q.dy = rnd_span(20);
        default: q.dz = rnd_span(20);
      endcase
    end else if (r < 80) begin
      q.dy = q.dx; q.dz = $urandom_range(0, 1) ? q.dx : -q.dx;
    end else if (r < 86) begin
      q.dx = 0; q.dy = 0; q.dz = 0;
    end else begin
      q.dx = rnd_span(3); q.dy = rnd_span(3); q.dz = rnd_span(3);
    end
  endfunction

  function automatic void rand_quat(ref query_t q);
    int r;
    r = $urandom_range(0, 99);
    q.qx = 0; q.qy = 0; q.qz = 0; q.qw = Q_ONE;
    if (r < 40) begin
      // identity, right-angle, half-turn and axis-permuting rotations
      case ($urandom_range(0, 6))
        0: ;
        1: begin q.qw = Q_HALF; q.qx = Q_HALF; end
        2: begin q.qw = Q_HALF; q.qy = -Q_HALF; end
        3: begin q.qw = Q_HALF; q.qz = Q_HALF; end
        4: begin q.qw = 0; q.qx = Q_ONE; end
        5: begin q.qw = -Q_ONE; end
        default: begin q.qw = Q_ONE >>> 1; q.qx = Q_ONE >>> 1;
                       q.qy = -(Q_ONE >>> 1); q.qz = Q_ONE >>> 1; end
      endcase
    end else if (r < 75) begin
      q.qx = rnd_span(30); q.qy = rnd_span(30); q.qz = rnd_span(30); q.qw = rnd_span(30);
    end else begin
      q.qx = $urandom; q.qy = $urandom; q.qz = $urandom; q.qw = $urandom;
    end
  endfunction

  function automatic query_t rand_query();
    query_t q;
    rand_dir(q);
    rand_quat(q);
    if ($urandom_range(0, 2) == 0) begin
      q.px = $urandom; q.py = $urandom; q.pz = $urandom;
    end else begin
      q.px = rnd_span(24); q.py = rnd_span(24); q.pz = rnd_span(24);
    end
    q.b = $urandom_range(0, 3) == 0 ? $signed($urandom) : rnd_span(20);
    if ($urandom_range(0, 9) == 0) q.b = 0;
    return q;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_query(rand_query());
    end_queries();
  endtask

  function automatic query_t mk(logic signed [31:0] dx, dy, dz, px, py, pz,
                                qx, qy, qz, qw, b);
    query_t q;
    q.dx = dx; q.dy = dy; q.dz = dz; q.px = px; q.py = py; q.pz = pz;
    q.qx = qx; q.qy = qy; q.qz = qz; q.qw = qw; q.b = b;
    return q;
  endfunction

  // directed queries: identity and turned boxes, zero direction, ties,
  // non-unit quaternions and saturation at both ends
  task automatic send_directed();
    send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, Q_ONE, 32'sd65536));
    send_query(mk(32'sd65536, 0, 0, 0, 0, 0, 0, 0, 0, Q_ONE, 0));
    send_query(mk(-32'sd65536, 0, 0, 100, -100, 7, 0, 0, 0, Q_ONE, 32'sd65536));
    send_query(mk(0, 32'sd65536, 0, 0, 0, 0, 0, 0, 0, Q_ONE, -32'sd65536));
    send_query(mk(0, 0, -1, 0, 0, 0, 0, 0, 0, Q_ONE, 32'sd131072));
    send_query(mk(1, 1, 1, 0, 0, 0, 0, 0, 0, Q_ONE, 32'sd65536));
    send_query(mk(32'sd65536, 32'sd65536, 0, 0, 0, 0, 0, 0, Q_HALF, Q_HALF, 32'sd1000));
    send_query(mk(32'sd65536, 0, 0, 0, 0, 0, Q_HALF, 0, 0, Q_HALF, 0));
    send_query(mk(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0, 0, 0, Q_ONE, S_MAX));
    send_query(mk(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0, Q_ONE, S_MAX));
    send_query(mk(S_MIN, 0, 0, 0, 0, 0, 0, 0, 0, Q_ONE, S_MIN));
    send_query(mk(S_MAX, S_MIN, 1, 0, 0, 0, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN));
    send_query(mk(-1, 2, -3, 0, 0, 0, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX));
    send_query(mk(5, 5, 5, 0, 0, 0, S_MAX, S_MIN, S_MAX, S_MIN, 32'sd65536));
    send_query(mk(32'sd65536, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'sd65536));
    send_query(mk(0, 0, 0, S_MAX, S_MIN, S_MAX, S_MAX, 0, 0, 0, S_MIN));
    send_query(mk(-32'sd3, 32'sd4, 0, -32'sd65536, 0, 0, 0, Q_ONE, 0, 0, -32'sd5));
    send_query(mk(32'sd1 <<< 30, 0, 0, 0, 0, 0, 0, 0, 0, -Q_ONE, S_MAX));
    send_query(mk(32'sh40000001, -32'sh3fffffff, 0, 0, 0, 0, 0, 0, 0, Q_ONE, S_MIN));
    send_query(mk(32'sd65536, 32'sd65536, 32'sd65536, 0, 0, 0, 32'sd536870912,
                  32'sd536870912, 32'sd536870912, 32'sd536870912, 32'sd65536));
    end_queries();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset corners are all zero, every corner ties
    send_random(30);
    drain();

    load_box(-32'sd65536, -32'sd131072, -32'sd32768, 32'sd65536, 32'sd131072, 32'sd32768);
    send_directed();
    drain();

    // fill the block against a long hold-off on the result side
    hold_req = ~hold_req;
    no_gaps = 1;
    send_random(150);
    no_gaps = 0;
    send_random(PHASE_ITEMS - 150);
    drain();

    // widest box both ways
    load_box(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX);
    send_random(PHASE_ITEMS);
    drain();

    // min above max, used as given
    load_box(S_MAX, 32'sd300000, -32'sd5, S_MIN, -32'sd300000, -32'sd6);
    send_random(PHASE_ITEMS);
    drain();

    load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_random(PHASE_ITEMS);
    drain();

    load_box(rnd_span(22), rnd_span(22), rnd_span(22), rnd_span(22), rnd_span(22),
             rnd_span(22));
    send_random(PHASE_ITEMS);
    drain();

    if (sb.outstanding() != 0) report($sformatf("%0d support points never came",
                                                sb.outstanding()));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/bsp_pkg.sv
rtl/bsp_select.sv
rtl/bsp_offset.sv
rtl/box_support_point.sv
bench/testbench.sv
